[hdl/ihex_pkg.sv]
// Shared types and codes for the hex record parser.
`timescale 1ns / 1ps

package ihex_pkg;

  // Line parsing phase, one-hot.
  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_HEAD  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_OFFS  = 5'b01000,
    PH_SKIP  = 5'b10000
  } phase_e;

  // Result kinds.
  localparam logic [1:0] RK_WRITE = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_START = 3'd0;
  localparam logic [2:0] ERR_HEX   = 3'd1;
  localparam logic [2:0] ERR_SHORT = 3'd2;
  localparam logic [2:0] ERR_TYPE  = 3'd3;
  localparam logic [2:0] ERR_NOEND = 3'd4;

  // Record types.
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEG_OFS = 8'h02;
  localparam logic [7:0] REC_LIN_OFS = 8'h04;

  // Characters.
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Header digit positions at which a byte completes.
  localparam logic [9:0] POS_LEN     = 10'd2;
  localparam logic [9:0] POS_ADDR_HI = 10'd4;
  localparam logic [9:0] POS_ADDR_LO = 10'd6;
  localparam logic [9:0] POS_TYPE    = 10'd8;
  localparam logic [9:0] POS_BODY    = 10'd10;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

endpackage

[hdl/intel_hex_record_parser_top.sv]
// Top level of the hex record parser: character decode, record state and result register.
`timescale 1ns / 1ps

// Takes hex record text one character per word (kind 1 marks end of input) and
// gives one result word per data byte of a data record, one done word at the
// type byte of an end record, or one error word; after done or error the block
// drops all further words until reset. Each word is handled at acceptance:
// the parse state updates and the result lands in the output register, so
// one word per cycle is sustained. A result waiting in the output register
// stalls input only while the sink holds ready low.
module intel_hex_record_parser_top
  import ihex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [32:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [2:0]  error_code_o
);

  // Parse state
  phase_e      phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic        hi_bad_q, hi_bad_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] load_q, load_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] offset_q, offset_d;
  logic        halted_q, halted_d;

  // Result register
  logic        out_valid_q;
  logic [1:0]  res_kind_q, res_kind_d;
  logic [32:0] res_addr_q, res_addr_d;
  logic [7:0]  res_data_q, res_data_d;
  logic [2:0]  res_err_q, res_err_d;
  logic        res_fire;

  logic        accept;
  logic [4:0]  dec;
  logic [7:0]  byte_val;
  logic [9:0]  pos_rel;
  logic [8:0]  idx;
  logic [15:0] body;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign dec      = hex_decode(character_i);
  assign byte_val = {hi_nib_q, dec[3:0]};
  assign pos_rel  = pos_q - POS_BODY;
  assign idx      = pos_rel[9:1];
  assign body     = {len_q, byte_val};

  // Next state and result for the presented word
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    hi_nib_d   = hi_nib_q;
    hi_bad_d   = hi_bad_q;
    len_d      = len_q;
    load_d     = load_q;
    type_d     = type_q;
    offset_d   = offset_q;
    halted_d   = halted_q;
    res_fire   = 1'b0;
    res_kind_d = RK_ERROR;
    res_addr_d = '0;
    res_data_d = '0;
    res_err_d  = '0;

    if (!halted_q) begin
      if (kind_i) begin
        // end of input
        res_fire = 1'b1;
        halted_d = 1'b1;
        if (phase_q == PH_HEAD || phase_q == PH_DATA || phase_q == PH_OFFS) begin
          res_err_d = ERR_SHORT;
        end else begin
          res_err_d = ERR_NOEND;
        end
      end else if (character_i == CH_NEWLINE) begin
        if (phase_q == PH_SKIP) begin
          phase_d = PH_START;
          pos_d   = '0;
        end else begin
          res_fire  = 1'b1;
          halted_d  = 1'b1;
          res_err_d = (phase_q == PH_START) ? ERR_START : ERR_SHORT;
        end
      end else if (phase_q == PH_START) begin
        if (character_i == CH_COLON) begin
          phase_d = PH_HEAD;
          pos_d   = 10'd1;
        end else begin
          res_fire  = 1'b1;
          halted_d  = 1'b1;
          res_err_d = ERR_START;
        end
      end else if (phase_q != PH_SKIP) begin
        pos_d = pos_q + 10'd1;
        if (pos_q[0]) begin
          // first digit of a pair
          hi_nib_d = dec[3:0];
          hi_bad_d = !dec[4];
        end else if (hi_bad_q || !dec[4]) begin
          res_fire  = 1'b1;
          halted_d  = 1'b1;
          res_err_d = ERR_HEX;
        end else begin
          // a full byte is in
          unique case (phase_q)
            PH_HEAD: begin
              if (pos_q == POS_LEN) begin
                len_d = byte_val;
              end else if (pos_q == POS_ADDR_HI) begin
                load_d = {byte_val, load_q[7:0]};
              end else if (pos_q == POS_ADDR_LO) begin
                load_d = {load_q[15:8], byte_val};
              end else if (pos_q == POS_TYPE) begin
                type_d = byte_val;
                if (byte_val == REC_DATA) begin
                  phase_d = (len_q == 8'd0) ? PH_SKIP : PH_DATA;
                end else if (byte_val == REC_EOF) begin
                  res_fire   = 1'b1;
                  halted_d   = 1'b1;
                  res_kind_d = RK_DONE;
                end else if ((byte_val == REC_SEG_OFS || byte_val == REC_LIN_OFS)
                             && len_q == 8'd2) begin
                  phase_d = PH_OFFS;
                end else begin
                  res_fire  = 1'b1;
                  halted_d  = 1'b1;
                  res_err_d = ERR_TYPE;
                end
              end
            end
            PH_DATA: begin
              res_fire   = 1'b1;
              res_kind_d = RK_WRITE;
              res_addr_d = {1'b0, offset_q} + 33'(load_q) + 33'(idx);
              res_data_d = byte_val;
              if ({1'b0, idx} + 10'd1 >= {2'b00, len_q}) begin
                phase_d = PH_SKIP;
              end
            end
            PH_OFFS: begin
              if (pos_q == POS_BODY) begin
                len_d = byte_val;
              end else begin
                if (type_q == REC_SEG_OFS) begin
                  offset_d = {12'd0, body, 4'd0};
                end else begin
                  offset_d = {body, 16'd0};
                end
                phase_d = PH_SKIP;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      pos_q    <= '0;
      hi_nib_q <= '0;
      hi_bad_q <= 1'b0;
      len_q    <= '0;
      load_q   <= '0;
      type_q   <= '0;
      offset_q <= '0;
      halted_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hi_nib_q <= hi_nib_d;
      hi_bad_q <= hi_bad_d;
      len_q    <= len_d;
      load_q   <= load_d;
      type_q   <= type_d;
      offset_q <= offset_d;
      halted_q <= halted_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res_fire;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept && res_fire) begin
      res_kind_q <= res_kind_d;
      res_addr_q <= res_addr_d;
      res_data_q <= res_data_d;
      res_err_q  <= res_err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = res_kind_q;
  assign write_address_o = res_addr_q;
  assign write_data_o    = res_data_q;
  assign error_code_o    = res_err_q;

endmodule
